/* rtl/keyed_accumulate_table_core_defines.svh */
// Assertion macros for the keyed accumulate table.
`ifndef KEYED_ACCUMULATE_TABLE_CORE_DEFINES_SVH
`define KEYED_ACCUMULATE_TABLE_CORE_DEFINES_SVH

// same-cycle implication
`define KAT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define KAT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/kat_pkg.sv */
// Types and constants shared by the keyed accumulate table.
`default_nettype none

package kat_pkg;

  localparam int ENTRIES_DEF  = 64;
  localparam int KEY_BITS_DEF = 64;
  localparam int KEY_W        = 64;
  localparam int AMOUNT_W     = 16;
  localparam int SUM_W        = 32;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  typedef enum logic [1:0] {
    FN_ADD   = 2'd0,
    FN_ERASE = 2'd1,
    FN_QUERY = 2'd2,
    FN_NONE  = 2'd3
  } func_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_t;

  typedef struct packed {
    func_t               func;
    logic [KEY_W-1:0]    key;
    logic [AMOUNT_W-1:0] amount;
  } in_item_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum_out;
    logic             found;
    logic             dropped_full;
  } out_item_t;

  typedef struct packed {
    logic                active;
    func_t               func;
    logic [KEY_W-1:0]    key;
    logic [AMOUNT_W-1:0] amount;
    logic                hit;
    logic [SUM_W-1:0]    sum;
    logic                free_seen;
  } tok_t;

  typedef struct packed {
    logic                en;
    logic [KEY_W-1:0]    key;
    logic [AMOUNT_W-1:0] amount;
  } alloc_t;

endpackage

`default_nettype wire

/* rtl/keyed_accumulate_table_core.sv */
// Keyed accumulate table: chain of entry cells with a scan controller.
//
//   channel | ports                        | payload
//   input   | in_valid, in_ready, in_data   | in_item_t (func, key, amount)
//   result  | out_valid, out_ready, out_data| out_item_t (sum_out, found, dropped_full)
//
// An item's token is first registered in the head, then passes through the cell
// chain one cell per cycle; as it leaves the last cell, the result is registered
// and any new entry is written. Reset clears all entry valid bits; no clearing pass.
// One item at a time; input is held off while scanning or while a result
// waits and out_ready is low.
`default_nettype none

module keyed_accumulate_table_core import kat_pkg::*; #(
  parameter int ENTRIES  = ENTRIES_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  `include "keyed_accumulate_table_core_defines.svh"

  localparam int IDX_W = $clog2(ENTRIES);

  state_t           state_r, state_nxt;
  tok_t             head_r, head_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_r, out_nxt;
  tok_t             tok_chain  [ENTRIES+1];
  logic [IDX_W-1:0] fidx_chain [ENTRIES+1];
  tok_t             last;
  alloc_t           alloc;
  logic             in_xfer;

  assign tok_chain[0]  = head_r;
  assign fidx_chain[0] = '0;
  assign last          = tok_chain[ENTRIES];

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    kat_cell #(
      .KEY_BITS(KEY_BITS),
      .IDX_W   (IDX_W),
      .IDX     (IDX_W'(i))
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .tok_i      (tok_chain[i]),
      .fidx_i     (fidx_chain[i]),
      .alloc_i    (alloc),
      .alloc_idx_i(fidx_chain[ENTRIES]),
      .tok_o      (tok_chain[i+1]),
      .fidx_o     (fidx_chain[i+1])
    );
  end

  assign in_ready = (state_r == ST_IDLE) && !(out_valid_r && !out_ready);
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    alloc.en     = last.active && (last.func == FN_ADD) && !last.hit && last.free_seen;
    alloc.key    = last.key;
    alloc.amount = last.amount;
  end

  always_comb begin
    state_nxt        = state_r;
    head_nxt         = head_r;
    head_nxt.active  = in_xfer;
    out_nxt          = out_r;
    out_valid_nxt    = out_valid_r;
    if (in_xfer) begin
      head_nxt.func      = in_data.func;
      head_nxt.key       = in_data.key;
      head_nxt.amount    = in_data.amount;
      head_nxt.hit       = 1'b0;
      head_nxt.sum       = '0;
      head_nxt.free_seen = 1'b0;
    end
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (last.active) begin
      out_valid_nxt        = 1'b1;
      out_nxt.sum_out      = last.sum;
      out_nxt.found        = last.hit;
      out_nxt.dropped_full = (last.func == FN_ADD) && !last.hit && !last.free_seen;
    end
    unique case (state_r)
      ST_IDLE: if (in_xfer) state_nxt = ST_SCAN;
      ST_SCAN: if (last.active) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      head_r.active <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `KAT_ASSERT_NXT(a_xfer_starts_scan, in_xfer, state_r == ST_SCAN, "transfer did not start scan")
  `KAT_ASSERT_IMP(a_exit_while_scan, last.active, state_r == ST_SCAN, "token left chain while idle")
  `KAT_ASSERT_IMP(a_exit_out_free, last.active, !out_valid_r, "result register still occupied")
  `KAT_ASSERT_IMP(a_found_xor_drop, out_valid_r, !(out_r.found && out_r.dropped_full), "found with drop")

endmodule

`default_nettype wire

/* rtl/kat_cell.sv */
// One table entry: key compare, sum update and token forwarding.
`default_nettype none

module kat_cell import kat_pkg::*; #(
  parameter int               KEY_BITS = KEY_BITS_DEF,
  parameter int               IDX_W    = 6,
  parameter logic [IDX_W-1:0] IDX      = '0
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire tok_t             tok_i,
  input  wire logic [IDX_W-1:0] fidx_i,
  input  wire alloc_t           alloc_i,
  input  wire logic [IDX_W-1:0] alloc_idx_i,
  output tok_t                  tok_o,
  output logic [IDX_W-1:0]      fidx_o
);

  logic                valid_r, valid_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  tok_t                tok_r, tok_nxt;
  logic [IDX_W-1:0]    fidx_r, fidx_nxt;
  logic                match;
  logic [SUM_W:0]      sum_add;

  assign match = tok_i.active && valid_r && (tok_i.func != FN_NONE) &&
                 (key_r == tok_i.key[KEY_BITS-1:0]);
  assign sum_add = {1'b0, sum_r} + {{(SUM_W-AMOUNT_W+1){1'b0}}, tok_i.amount};

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    sum_nxt   = sum_r;
    tok_nxt   = tok_i;
    fidx_nxt  = fidx_i;
    if (match) begin
      tok_nxt.hit = 1'b1;
      unique case (tok_i.func)
        FN_ADD:   sum_nxt = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
        FN_ERASE: valid_nxt = 1'b0;
        FN_QUERY: tok_nxt.sum = sum_r;
        default: ;
      endcase
    end
    if (tok_i.active && !valid_r && !tok_i.free_seen) begin
      tok_nxt.free_seen = 1'b1;
      fidx_nxt          = IDX;
    end
    if (alloc_i.en && (alloc_idx_i == IDX)) begin
      valid_nxt = 1'b1;
      key_nxt   = alloc_i.key[KEY_BITS-1:0];
      sum_nxt   = {{(SUM_W-AMOUNT_W){1'b0}}, alloc_i.amount};
    end
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    sum_r  <= sum_nxt;
    fidx_r <= fidx_nxt;
    if (!rst_n) begin
      valid_r      <= 1'b0;
      tok_r.active <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      tok_r   <= tok_nxt;
    end
  end

  assign tok_o  = tok_r;
  assign fidx_o = fidx_r;

endmodule

`default_nettype wire

/* tb/sv/tb_keyed_accumulate_table_core.sv */
// Self-checking testbench for the keyed accumulate table: directed rows, fill, random.
`default_nettype none

module tb_keyed_accumulate_table_core;
  import kat_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int              DEPTH       = ENTRIES_DEF;
  localparam logic [KEY_W-1:0] KEY_MASK   = (KEY_BITS_DEF >= 64) ? {KEY_W{1'b1}} :
                                            ((64'd1 << KEY_BITS_DEF) - 64'd1);
  localparam int              POOL        = 96;
  localparam int              RAND_ITEMS  = 340;
  localparam int              HOLD_CYCLES = 300;
  localparam longint          CYCLE_LIMIT = 400_000;
  localparam logic [KEY_W-1:0] ONES_KEY   = {KEY_W{1'b1}};
  localparam logic [KEY_W-1:0] ABC_KEY    = 64'h0000_0000_0061_6263;
  localparam logic [KEY_W-1:0] TOP_KEY    = 64'h8000_0000_0000_0000;
  localparam logic [KEY_W-1:0] ALT_KEY    = 64'h5555_5555_5555_5555;
  localparam logic [KEY_W-1:0] FILL_BASE  = 64'h1000_0000_0000_0000;

  typedef struct packed {
    func_t               func;
    logic [KEY_W-1:0]    key;
    logic [AMOUNT_W-1:0] amount;
    logic                fixed;
    logic [SUM_W-1:0]    sum;
    logic                found;
    logic                dropped;
  } row_t;

  row_t dir_rows [24] = '{
    '{FN_QUERY, 64'h0,     16'h0000, 1'b1, 32'h0,     1'b0, 1'b0},
    '{FN_ERASE, ONES_KEY,  16'h0000, 1'b1, 32'h0,     1'b0, 1'b0},
    '{FN_NONE,  ONES_KEY,  16'hffff, 1'b1, 32'h0,     1'b0, 1'b0},
    '{FN_ADD,   64'h0,     16'h0000, 1'b1, 32'h0,     1'b0, 1'b0},
    '{FN_QUERY, 64'h0,     16'h0000, 1'b1, 32'h0,     1'b1, 1'b0},
    '{FN_ADD,   64'h0,     16'hffff, 1'b1, 32'h0,     1'b1, 1'b0},
    '{FN_ADD,   64'h0,     16'hffff, 1'b1, 32'h0,     1'b1, 1'b0},
    '{FN_QUERY, 64'h0,     16'h0000, 1'b1, 32'h1fffe, 1'b1, 1'b0},
    '{FN_ADD,   ONES_KEY,  16'h0001, 1'b1, 32'h0,     1'b0, 1'b0},
    '{FN_QUERY, ONES_KEY,  16'h0000, 1'b1, 32'h1,     1'b1, 1'b0},
    '{FN_ADD,   ABC_KEY,   16'h1234, 1'b1, 32'h0,     1'b0, 1'b0},
    '{FN_ERASE, 64'h0,     16'h0000, 1'b1, 32'h0,     1'b1, 1'b0},
    '{FN_QUERY, 64'h0,     16'h0000, 1'b1, 32'h0,     1'b0, 1'b0},
    '{FN_ADD,   TOP_KEY,   16'h0007, 1'b1, 32'h0,     1'b0, 1'b0},
    '{FN_QUERY, TOP_KEY,   16'hffff, 1'b1, 32'h7,     1'b1, 1'b0},
    '{FN_QUERY, 64'h1,     16'h0000, 1'b1, 32'h0,     1'b0, 1'b0},
    '{FN_QUERY, ABC_KEY,   16'h0000, 1'b1, 32'h1234,  1'b1, 1'b0},
    '{FN_ADD,   ABC_KEY,   16'hffff, 1'b1, 32'h0,     1'b1, 1'b0},
    '{FN_QUERY, ABC_KEY,   16'h0000, 1'b0, 32'h0,     1'b0, 1'b0},
    '{FN_ERASE, ONES_KEY,  16'h0000, 1'b1, 32'h0,     1'b1, 1'b0},
    '{FN_ERASE, ONES_KEY,  16'h0000, 1'b1, 32'h0,     1'b0, 1'b0},
    '{FN_NONE,  64'h0,     16'h0000, 1'b1, 32'h0,     1'b0, 1'b0},
    '{FN_ADD,   ALT_KEY,   16'haaaa, 1'b1, 32'h0,     1'b0, 1'b0},
    '{FN_QUERY, ALT_KEY,   16'h0000, 1'b0, 32'h0,     1'b0, 1'b0}
  };

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  // fixed result that travels with the item on offer
  logic      fixed_flag;
  out_item_t fixed_res;

  logic                tbl_valid [DEPTH];
  logic [KEY_W-1:0]    tbl_key   [DEPTH];
  logic [SUM_W-1:0]    tbl_sum   [DEPTH];
  out_item_t           results_due [$];
  logic [KEY_W-1:0]    key_pool [POOL];

  bit     idle_en;
  bit     hold_pending;
  int     errors;
  int     n_in;
  int     n_out;
  int     n_drop;
  longint cycles;

  keyed_accumulate_table_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic out_item_t table_apply(in_item_t it);
    out_item_t        r;
    logic [KEY_W-1:0] k;
    logic [SUM_W:0]   total;
    int               hit;
    int               free_slot;
    r = '0;
    k = it.key & KEY_MASK;
    hit = -1;
    free_slot = -1;
    for (int i = 0; i < DEPTH; i++) begin
      if (hit < 0 && tbl_valid[i] && tbl_key[i] == k) hit = i;
      if (free_slot < 0 && !tbl_valid[i]) free_slot = i;
    end
    case (it.func)
      FN_ADD: begin
        if (hit >= 0) begin
          total = {1'b0, tbl_sum[hit]} + {{(SUM_W + 1 - AMOUNT_W){1'b0}}, it.amount};
          tbl_sum[hit] = total[SUM_W] ? SUM_MAX : total[SUM_W-1:0];
          r.found = 1'b1;
        end else if (free_slot >= 0) begin
          tbl_valid[free_slot] = 1'b1;
          tbl_key[free_slot] = k;
          tbl_sum[free_slot] = {{(SUM_W - AMOUNT_W){1'b0}}, it.amount};
        end else begin
          r.dropped_full = 1'b1;
        end
      end
      FN_ERASE: begin
        if (hit >= 0) begin
          tbl_valid[hit] = 1'b0;
          r.found = 1'b1;
        end
      end
      FN_QUERY: begin
        if (hit >= 0) begin
          r.sum_out = tbl_sum[hit];
          r.found = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_en || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_op(in_item_t it, logic use_fixed, out_item_t res);
    int gap;
    in_valid   <= 1'b1;
    in_data    <= it;
    fixed_flag <= use_fixed;
    fixed_res  <= res;
    do @(posedge clk); while (!in_ready);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // scoreboard: predict on input transfer, compare on result transfer
  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = out_data;
        n_out++;
        if (results_due.size() == 0) begin
          $display("%0t: result with none pending: actual %h", $time, got);
          errors++;
        end else begin
          want = results_due.pop_front();
          if (got.sum_out !== want.sum_out) begin
            $display("%0t: sum_out mismatch: expected %h, actual %h",
                     $time, want.sum_out, got.sum_out);
            errors++;
          end
          if (got.found !== want.found) begin
            $display("%0t: found mismatch: expected %b, actual %b",
                     $time, want.found, got.found);
            errors++;
          end
          if (got.dropped_full !== want.dropped_full) begin
            $display("%0t: dropped_full mismatch: expected %b, actual %b",
                     $time, want.dropped_full, got.dropped_full);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        want = table_apply(in_data);
        if (fixed_flag) want = fixed_res;
        if (want.dropped_full) n_drop++;
        results_due.push_back(want);
        n_in++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results pending", $time, results_due.size());
      $display("tb_keyed_accumulate_table_core failed");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!idle_en) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 1) != 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk);
      end
    end
  end

  initial begin
    in_item_t  it;
    out_item_t res;
    int        counted;
    int        mode;
    int        r;
    int        len;
    bit        hold_done;

    errors = 0;
    n_in = 0;
    n_out = 0;
    n_drop = 0;
    cycles = 0;
    idle_en = 1'b1;
    hold_pending = 1'b0;
    hold_done = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_key[i] = '0;
      tbl_sum[i] = '0;
    end
    for (int i = 0; i < POOL; i++) begin
      if (i % 2 == 1) begin
        key_pool[i] = {$urandom, $urandom};
      end else begin
        key_pool[i] = '0;
        len = $urandom_range(1, 8);
        for (int b = 0; b < len; b++)
          key_pool[i][8*b +: 8] = 8'($urandom_range(97, 122));
      end
    end

    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_data    <= '0;
    fixed_flag <= 1'b0;
    fixed_res  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      it.func   = dir_rows[i].func;
      it.key    = dir_rows[i].key;
      it.amount = dir_rows[i].amount;
      res.sum_out      = dir_rows[i].sum;
      res.found        = dir_rows[i].found;
      res.dropped_full = dir_rows[i].dropped;
      send_op(it, dir_rows[i].fixed, res);
    end

    // fill to capacity and past it, add to a present key, free one entry, then erase all fill keys
    res = '0;
    for (int i = 0; i < DEPTH + 3; i++) begin
      it.func = FN_ADD;
      it.key = FILL_BASE | KEY_W'(i);
      it.amount = 16'($urandom);
      send_op(it, 1'b0, res);
    end
    it.func = FN_ADD;
    it.key = FILL_BASE | 64'd5;
    send_op(it, 1'b0, res);
    it.func = FN_ERASE;
    it.key = FILL_BASE | 64'd10;
    send_op(it, 1'b0, res);

    for (int i = 0; i < DEPTH + 3; i++) begin
      it.func = FN_ERASE;
      it.key = FILL_BASE | KEY_W'(i);
      send_op(it, 1'b0, res);
    end

    // random blocks: fill, mixed and drain patterns, mostly over a shared key pool
    counted = 0;
    while (counted < RAND_ITEMS) begin
      mode = $urandom_range(0, 2);
      idle_en = ($urandom_range(0, 3) != 0);
      for (int j = 0; j < 60 && counted < RAND_ITEMS; j++) begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          it.func = FN_NONE;
        end else begin
          r = $urandom_range(0, 99);
          case (mode)
            0: it.func = (r < 75) ? FN_ADD : (r < 80) ? FN_ERASE : FN_QUERY;
            1: it.func = (r < 40) ? FN_ADD : (r < 65) ? FN_ERASE : FN_QUERY;
            default: it.func = (r < 15) ? FN_ADD : (r < 70) ? FN_ERASE : FN_QUERY;
          endcase
          counted++;
        end
        it.key = ($urandom_range(0, 99) < 88) ? key_pool[$urandom_range(0, POOL - 1)] :
                 {$urandom, $urandom};
        r = $urandom_range(0, 9);
        it.amount = (r == 0) ? 16'hffff : (r == 1) ? 16'h0000 : 16'($urandom);
        if (!hold_done && counted >= 150) begin
          hold_done = 1'b1;
          hold_pending = 1'b1;
        end
        send_op(it, 1'b0, res);
      end
    end
    in_valid <= 1'b0;

    while (results_due.size() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);

    $display("%0d operations sent, %0d results checked, including reset, zero and",
             n_in, n_out);
    $display("all-ones keys, a full table with %0d adds refused, and a long result stall",
             n_drop);
    if (errors == 0 && results_due.size() == 0) begin
      $display("tb_keyed_accumulate_table_core passed");
    end else begin
      $display("%0d mismatches, %0d results never arrived", errors, results_due.size());
      $display("tb_keyed_accumulate_table_core failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
